### rtl/core/slot_grant_wait_queue_unit_macros.svh
// Assertion macros for the slot grant wait queue unit.
// Included by the top level; needs no other file.
`ifndef SLOT_GRANT_WAIT_QUEUE_UNIT_MACROS_SVH
`define SLOT_GRANT_WAIT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SGWQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SGWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sgwq_pkg.sv
// Shared types and constants for the slot grant wait queue unit.
// No dependencies; used by every module of the unit.
`default_nettype none

package sgwq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_AW          = $clog2(MAX_RESULTS);
   localparam int RES_NW          = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IW          = 8;

   localparam logic [7:0]  SLOT_COUNT_RESET = 8'd16;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd1000;

   localparam logic [CSR_IW-1:0] CSR_SLOT_COUNT = 8'd0;
   localparam logic [CSR_IW-1:0] CSR_TIMEOUT    = 8'd1;

   localparam logic [1:0] CMD_ARRIVE  = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   localparam logic [2:0] EV_GRANTED  = 3'd0;
   localparam logic [2:0] EV_QUEUED   = 3'd1;
   localparam logic [2:0] EV_REJECTED = 3'd2;
   localparam logic [2:0] EV_FREED    = 3'd3;
   localparam logic [2:0] EV_IGNORED  = 3'd4;
   localparam logic [2:0] EV_TIMEOUT  = 3'd5;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_PUSH_FRONT,
      CELL_POP_HEAD,
      CELL_DROP_EXPIRED,
      CELL_AGE
   } sgwq_cell_op_type;

   typedef struct packed {
      sgwq_cell_op_type op;
      logic [15:0]      new_id;
   } sgwq_cell_ctrl_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] age;
   } sgwq_entry_type;

   // first-expired search, rippled head to tail
   typedef struct packed {
      logic        hit;
      logic [15:0] id;
   } sgwq_scan_type;

   typedef struct packed {
      logic [2:0]  ev;
      logic [15:0] id;
   } sgwq_result_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] client_id;
      logic        is_vip;
   } sgwq_req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] subject_id;
      logic [7:0]  free_after;
      logic [4:0]  waiting_after;
      logic        last_result;
   } sgwq_rsp_type;

endpackage

`default_nettype wire

### rtl/core/sgwq_cell.sv
// One wait queue position: holds an id and its age, shifts with neighbors.
// Depends on sgwq_pkg.
`default_nettype none

module sgwq_cell (
   input  logic                    clock,
   input  sgwq_pkg::sgwq_cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    at_tail,
   input  logic [31:0]             timeout,
   input  sgwq_pkg::sgwq_entry_type left_entry,
   input  sgwq_pkg::sgwq_entry_type right_entry,
   input  sgwq_pkg::sgwq_scan_type  scan_in,
   output sgwq_pkg::sgwq_entry_type entry,
   output sgwq_pkg::sgwq_scan_type  scan_out
);
   import sgwq_pkg::*;

   sgwq_entry_type entry_ff;
   sgwq_entry_type entry_in;
   logic           expired;

   assign expired = occupied && (entry_ff.age >= timeout);
   assign entry   = entry_ff;

   always_comb begin
      scan_out.hit = scan_in.hit | expired;
      if (scan_in.hit) begin
         scan_out.id = scan_in.id;
      end else if (expired) begin
         scan_out.id = entry_ff.id;
      end else begin
         scan_out.id = '0;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_APPEND: begin
            if (at_tail) begin
               entry_in.id  = ctrl.new_id;
               entry_in.age = '0;
            end
         end
         CELL_PUSH_FRONT: begin
            entry_in = left_entry;
         end
         CELL_POP_HEAD: begin
            entry_in = right_entry;
         end
         CELL_DROP_EXPIRED: begin
            // everything from the first expired entry on moves up one
            if (scan_out.hit) begin
               entry_in = right_entry;
            end
         end
         CELL_AGE: begin
            if (entry_ff.age != '1) begin
               entry_in.age = entry_ff.age + 32'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

### rtl/core/sgwq_result_buf.sv
// Result buffer: collects the results of one item until its counts are final.
// Depends on sgwq_pkg.
`default_nettype none

module sgwq_result_buf (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sgwq_pkg::RES_AW-1:0]  wr_addr,
   input  sgwq_pkg::sgwq_result_type    wr_data,
   input  logic [sgwq_pkg::RES_AW-1:0]  rd_addr,
   output sgwq_pkg::sgwq_result_type    rd_data
);
   import sgwq_pkg::*;

   sgwq_result_type mem [MAX_RESULTS];
   sgwq_result_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/slot_grant_wait_queue_unit.sv
// Slot admission controller with a priority wait queue kept in a cell chain.
// An arrive or release runs its command state and S_GRANT, a tick S_TICK, S_EXPIRE
// and S_GRANT; then S_PREP and S_DRAIN if it has results, which leave one a cycle
// while rsp_stall is low. One item in flight; next accept the cycle after its last beat.
// Reset: synchronous; queue empty, slot_count 16, free 16, timeout 1000.
// Queue contents are not cleared; no clearing pass.
`default_nettype none

`include "slot_grant_wait_queue_unit_macros.svh"

module slot_grant_wait_queue_unit #(
   parameter int QUEUE_DEPTH = sgwq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sgwq_pkg::sgwq_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sgwq_pkg::sgwq_rsp_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sgwq_pkg::CSR_IW-1:0]   csr_index,
   input  logic [31:0]                   csr_data
);
   import sgwq_pkg::*;

   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > RES_NW) ? CW : RES_NW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ARRIVE,
      S_RELEASE,
      S_TICK,
      S_EXPIRE,
      S_GRANT,
      S_PREP,
      S_DRAIN
   } state_type;

   // what the grant pass still owes once it runs dry
   typedef enum logic [1:0] {
      POST_NONE,
      POST_QUEUED,
      POST_FREED
   } post_type;

   state_type         state_ff, state_in;
   post_type          post_ff, post_in;
   logic [15:0]       id_ff, id_in;
   logic              vip_ff, vip_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [RES_NW-1:0] grants_ff, grants_in;
   logic [RES_NW-1:0] res_n_ff, res_n_in;
   logic [RES_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [7:0]        free_ff, free_in;
   logic [7:0]        slot_count_ff, slot_count_in;
   logic [31:0]       timeout_ff, timeout_in;
   logic [31:0]       total_ff, total_in;

   sgwq_cell_ctrl_type cell_ctrl;
   sgwq_entry_type     cell_entry [QUEUE_DEPTH];
   sgwq_scan_type      scan_chain [QUEUE_DEPTH+1];
   sgwq_scan_type      scan_res;

   logic              push_req;
   logic              wr_en;
   sgwq_result_type   push_res;
   sgwq_result_type   rd_data;
   logic              cap_ok;
   logic              can_grant;
   logic              last;
   logic [CMPW-1:0]   grants_cmp, pos_cmp;
   logic [CW+4:0]     count_ext;

   assign scan_chain[0] = '0;
   assign scan_res      = scan_chain[QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sgwq_entry_type left_e;
      sgwq_entry_type right_e;
      logic           occ;
      logic           tail;

      if (i == 0) begin : g_head
         assign left_e.id  = id_ff;
         assign left_e.age = '0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      assign occ  = CW'(i) < count_ff;
      assign tail = CW'(i) == count_ff;

      sgwq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .occupied    (occ),
         .at_tail     (tail),
         .timeout     (timeout_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .scan_in     (scan_chain[i]),
         .entry       (cell_entry[i]),
         .scan_out    (scan_chain[i+1])
      );
   end

   sgwq_result_buf u_result_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (res_n_ff[RES_AW-1:0]),
      .wr_data (push_res),
      .rd_addr (rd_ptr_in),
      .rd_data (rd_data)
   );

   assign cap_ok     = res_n_ff < RES_NW'(MAX_RESULTS);
   assign can_grant  = (free_ff != '0) && (count_ff != '0) && cap_ok;
   assign wr_en      = push_req && cap_ok;
   assign grants_cmp = CMPW'(grants_ff);
   assign pos_cmp    = CMPW'(pos_ff);
   assign last       = (RES_NW'(rd_ptr_ff) + RES_NW'(1)) == res_n_ff;
   assign count_ext  = (CW+5)'(count_ff);

   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_DRAIN;

   always_comb begin
      rsp_data.event_res     = rd_data.ev;
      rsp_data.subject_id    = rd_data.id;
      rsp_data.free_after    = free_ff;
      rsp_data.waiting_after = count_ext[4:0];
      rsp_data.last_result   = last;
   end

   always_comb begin
      state_in      = state_ff;
      post_in       = post_ff;
      id_in         = id_ff;
      vip_in        = vip_ff;
      pos_in        = pos_ff;
      grants_in     = grants_ff;
      res_n_in      = res_n_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      slot_count_in = slot_count_ff;
      timeout_in    = timeout_ff;
      total_in      = total_ff;
      cell_ctrl.op     = CELL_HOLD;
      cell_ctrl.new_id = id_ff;
      push_req      = 1'b0;
      push_res.ev   = EV_GRANTED;
      push_res.id   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               unique case (csr_index)
                  CSR_SLOT_COUNT: begin
                     slot_count_in = csr_data[7:0];
                     free_in       = csr_data[7:0];
                  end
                  CSR_TIMEOUT: begin
                     timeout_in = csr_data;
                  end
                  default: begin
                  end
               endcase
            end
            if (req_valid) begin
               id_in     = req_data.client_id;
               vip_in    = req_data.is_vip;
               res_n_in  = '0;
               grants_in = '0;
               rd_ptr_in = '0;
               post_in   = POST_NONE;
               unique case (req_data.command)
                  CMD_ARRIVE:  state_in = S_ARRIVE;
                  CMD_RELEASE: state_in = S_RELEASE;
                  CMD_TICK:    state_in = S_TICK;
                  default:     state_in = S_GRANT;
               endcase
            end
         end
         S_ARRIVE: begin
            if (count_ff == CW'(QUEUE_DEPTH)) begin
               push_req    = 1'b1;
               push_res.ev = EV_REJECTED;
               push_res.id = id_ff;
            end else begin
               cell_ctrl.op = vip_ff ? CELL_PUSH_FRONT : CELL_APPEND;
               pos_in       = vip_ff ? '0 : count_ff;
               count_in     = count_ff + CW'(1);
               post_in      = POST_QUEUED;
            end
            state_in = S_GRANT;
         end
         S_RELEASE: begin
            if (free_ff < slot_count_ff) begin
               free_in = free_ff + 8'd1;
               post_in = POST_FREED;
            end else begin
               push_req    = 1'b1;
               push_res.ev = EV_IGNORED;
            end
            state_in = S_GRANT;
         end
         S_TICK: begin
            cell_ctrl.op = CELL_AGE;
            state_in     = S_EXPIRE;
         end
         S_EXPIRE: begin
            // one expired entry leaves per cycle, lowest position first
            if (scan_res.hit && cap_ok) begin
               push_req     = 1'b1;
               push_res.ev  = EV_TIMEOUT;
               push_res.id  = scan_res.id;
               cell_ctrl.op = CELL_DROP_EXPIRED;
               count_in     = count_ff - CW'(1);
               total_in     = total_ff + 32'd1;
            end else begin
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (can_grant) begin
               push_req     = 1'b1;
               push_res.ev  = EV_GRANTED;
               push_res.id  = cell_entry[0].id;
               cell_ctrl.op = CELL_POP_HEAD;
               free_in      = free_ff - 8'd1;
               count_in     = count_ff - CW'(1);
               grants_in    = grants_ff + RES_NW'(1);
            end else begin
               if (post_ff == POST_QUEUED && grants_cmp <= pos_cmp) begin
                  push_req    = 1'b1;
                  push_res.ev = EV_QUEUED;
                  push_res.id = id_ff;
               end else if (post_ff == POST_FREED && grants_ff == '0) begin
                  push_req    = 1'b1;
                  push_res.ev = EV_FREED;
               end
               if (wr_en || res_n_ff != '0) begin
                  state_in = S_PREP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PREP: begin
            // the buffer registers the read of the first result here, ready for S_DRAIN
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!rsp_stall) begin
               if (last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + RES_AW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         res_n_in = res_n_ff + RES_NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         post_ff       <= POST_NONE;
         grants_ff     <= '0;
         res_n_ff      <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         free_ff       <= SLOT_COUNT_RESET;
         slot_count_ff <= SLOT_COUNT_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         post_ff       <= post_in;
         grants_ff     <= grants_in;
         res_n_ff      <= res_n_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         free_ff       <= free_in;
         slot_count_ff <= slot_count_in;
         timeout_ff    <= timeout_in;
         total_ff      <= total_in;
      end
      id_ff  <= id_in;
      vip_ff <= vip_in;
      pos_ff <= pos_in;
   end

   `SGWQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "queue count over depth")
   `SGWQ_ASSERT_NOW(a_result_cap, clock, reset, 1'b1, res_n_ff <= RES_NW'(MAX_RESULTS), "result count over cap")
   `SGWQ_ASSERT_NOW(a_free_bound, clock, reset, 1'b1, free_ff <= slot_count_ff, "free slots exceed pool size")
   `SGWQ_ASSERT_NEXT(a_last_beat_idle, clock, reset, rsp_valid && !rsp_stall && last, state_ff == S_IDLE, "no idle after last beat")

endmodule

`default_nettype wire

### tb/sv/tb_slot_grant_wait_queue_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for slot_grant_wait_queue_unit: directed and random
// arrive, release and tick beats, checked against an admission predictor.
// Depends on sgwq_pkg and the unit RTL only.

module tb_slot_grant_wait_queue_unit;
   import sgwq_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 60;

   class admission_scoreboard;
      logic [7:0]   pool_size;
      logic [31:0]  wait_limit;
      logic [7:0]   free_cnt;
      logic [31:0]  expired_total;
      logic [15:0]  wait_id[$];
      logic [31:0]  wait_age[$];
      logic [2:0]   item_ev[$];
      logic [15:0]  item_id[$];
      sgwq_rsp_type due_results[$];
      int           mismatches;

      function new();
         pool_size     = SLOT_COUNT_RESET;
         wait_limit    = TIMEOUT_RESET;
         free_cnt      = SLOT_COUNT_RESET;
         expired_total = '0;
         mismatches    = 0;
      endfunction

      function void write_register(logic [CSR_IW-1:0] index, logic [31:0] value);
         if (index == CSR_SLOT_COUNT) begin
            pool_size = value[7:0];
            free_cnt  = value[7:0];
         end else if (index == CSR_TIMEOUT) begin
            wait_limit = value;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      // anything past the per-item result cap is dropped here
      function void record(logic [2:0] ev, logic [15:0] id);
         if (item_ev.size() < MAX_RESULTS) begin
            item_ev.push_back(ev);
            item_id.push_back(id);
         end
      endfunction

      function int grant_heads();
         int granted;
         granted = 0;
         while (free_cnt != 0 && wait_id.size() != 0 && item_ev.size() < MAX_RESULTS) begin
            record(EV_GRANTED, wait_id.pop_front());
            void'(wait_age.pop_front());
            free_cnt--;
            granted++;
         end
         return granted;
      endfunction

      function void note_request(sgwq_req_type req);
         int           slot_pos;
         int           k;
         sgwq_rsp_type beat;
         item_ev.delete();
         item_id.delete();
         case (req.command)
            CMD_ARRIVE: begin
               if (wait_id.size() >= QUEUE_DEPTH_DEF) begin
                  record(EV_REJECTED, req.client_id);
                  void'(grant_heads());
               end else begin
                  if (req.is_vip) begin
                     wait_id.push_front(req.client_id);
                     wait_age.push_front('0);
                     slot_pos = 0;
                  end else begin
                     slot_pos = wait_id.size();
                     wait_id.push_back(req.client_id);
                     wait_age.push_back('0);
                  end
                  // still waiting unless the grant pass reached its position
                  if (grant_heads() <= slot_pos) record(EV_QUEUED, req.client_id);
               end
            end
            CMD_RELEASE: begin
               if (free_cnt < pool_size) begin
                  free_cnt++;
                  if (grant_heads() == 0) record(EV_FREED, '0);
               end else begin
                  record(EV_IGNORED, '0);
                  void'(grant_heads());
               end
            end
            CMD_TICK: begin
               foreach (wait_age[i])
                  if (wait_age[i] != '1) wait_age[i]++;
               k = 0;
               while (k < wait_id.size()) begin
                  if (wait_age[k] >= wait_limit && item_ev.size() < MAX_RESULTS) begin
                     record(EV_TIMEOUT, wait_id[k]);
                     wait_id.delete(k);
                     wait_age.delete(k);
                     expired_total++;
                  end else begin
                     k++;
                  end
               end
               void'(grant_heads());
            end
            default: begin
               void'(grant_heads());
            end
         endcase
         foreach (item_ev[i]) begin
            beat.event_res     = item_ev[i];
            beat.subject_id    = item_id[i];
            beat.free_after    = free_cnt;
            beat.waiting_after = 5'(wait_id.size());
            beat.last_result   = (i == item_ev.size() - 1);
            due_results.push_back(beat);
         end
      endfunction

      function void check_result(sgwq_rsp_type got);
         sgwq_rsp_type want;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected result: ev %0d id %h free %0d wait %0d last %0b",
                             got.event_res, got.subject_id, got.free_after,
                             got.waiting_after, got.last_result));
         end else begin
            want = due_results.pop_front();
            if (got.event_res !== want.event_res || got.subject_id !== want.subject_id ||
                got.free_after !== want.free_after ||
                got.waiting_after !== want.waiting_after ||
                got.last_result !== want.last_result) begin
               report($sformatf({"result mismatch: expected ev %0d id %h free %0d wait %0d",
                                 " last %0b, got ev %0d id %h free %0d wait %0d last %0b"},
                                want.event_res, want.subject_id, want.free_after,
                                want.waiting_after, want.last_result, got.event_res,
                                got.subject_id, got.free_after, got.waiting_after,
                                got.last_result));
            end
         end
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   sgwq_req_type        req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   sgwq_rsp_type        rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_IW-1:0]   csr_index = '0;
   logic [31:0]         csr_data  = '0;

   int                  gap_pct   = 0;
   int                  stall_pct = 0;
   admission_scoreboard board;

   slot_grant_wait_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // handshake monitor: every accepted beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   // leaves valid high on return; the next call or settle() decides what follows
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] id, input logic vip);
      sgwq_req_type beat;
      beat.command   = cmd;
      beat.client_id = id;
      beat.is_vip    = vip;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_items(input int count);
      int         roll;
      logic [1:0] cmd;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)      cmd = CMD_ARRIVE;
         else if (roll < 67) cmd = CMD_RELEASE;
         else if (roll < 95) cmd = CMD_TICK;
         else                cmd = CMD_UNUSED;
         send_item(cmd, 16'($urandom()), ($urandom_range(0, 99) < 30));
      end
   endtask

   // drain all expected results, then allow for an item that emits nothing
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [7:0] slots, input logic [31:0] limit);
      logic [31:0] slot_word;
      slot_word       = $urandom();
      slot_word[7:0]  = slots;
      write_csr(CSR_SLOT_COUNT, slot_word);
      write_csr(CSR_TIMEOUT, limit);
      csr_valid <= 1'b0;
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: saturated release, grants, unused command
      send_item(CMD_RELEASE, 16'h0000, 1'b0);
      send_item(CMD_ARRIVE, 16'hFFFF, 1'b1);
      send_item(CMD_ARRIVE, 16'h0000, 1'b0);
      send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
      settle();

      // one slot, reloaded while two are held: queueing, priority, expiry
      configure(8'd1, 32'd2);
      send_item(CMD_ARRIVE, 16'h1234, 1'b0);
      send_item(CMD_ARRIVE, 16'hA5A5, 1'b0);
      send_item(CMD_ARRIVE, 16'h5A5A, 1'b1);
      send_item(CMD_ARRIVE, 16'h0F0F, 1'b1);
      send_item(CMD_RELEASE, 16'hFFFF, 1'b1);
      send_item(CMD_TICK, 16'h0000, 1'b0);
      send_item(CMD_TICK, 16'hFFFF, 1'b1);
      send_item(CMD_RELEASE, 16'h0000, 1'b0);
      send_item(CMD_RELEASE, 16'h0000, 1'b0);
      send_item(CMD_ARRIVE, 16'h8001, 1'b0);
      settle();

      // zero limit: everything waiting goes on the next tick
      configure(8'd1, 32'd0);
      send_item(CMD_ARRIVE, 16'h7FFE, 1'b0);
      send_item(CMD_ARRIVE, 16'h0001, 1'b0);
      send_item(CMD_ARRIVE, 16'h8000, 1'b1);
      send_item(CMD_TICK, 16'h0000, 1'b0);
      send_item(CMD_TICK, 16'h0000, 1'b0);
      settle();

      gap_pct   = 0;
      stall_pct = 0;
      configure(8'd3, 32'd4);
      random_items(35);
      settle();

      // fill past depth with one slot, then widen the pool so the next
      // arrival overflows the per-item result cap
      gap_pct   = 45;
      stall_pct = 0;
      configure(8'd1, 32'hFFFF_FFFF);
      repeat (20) send_item(CMD_ARRIVE, 16'($urandom()), 1'($urandom_range(0, 1)));
      settle();
      configure(8'd255, 32'hFFFF_FFFF);
      send_item(CMD_ARRIVE, 16'($urandom()), 1'($urandom_range(0, 1)));
      send_item(CMD_UNUSED, 16'($urandom()), 1'($urandom_range(0, 1)));
      random_items(10);
      settle();

      gap_pct   = 0;
      stall_pct = 45;
      configure(8'd2, 32'd0);
      random_items(15);
      settle();
      configure(8'd2, 32'd1);
      random_items(10);
      settle();

      gap_pct   = 11;
      stall_pct = 11;
      configure(8'd5, 32'd7);
      random_items(20);
      settle();

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
